[sv/pbg_pkg.sv]
// ---------------------------------------------------------------------------
// pbg_pkg: shared types and constants of the prior box generator
// Words of the input and result channels, configuration register indexes,
// fixed arithmetic widths and the controller to datapath command bundle.
// ---------------------------------------------------------------------------
`default_nettype none
package pbg_pkg;

  localparam int ROW_W   = 10;
  localparam int COORD_W = 16;
  localparam int DIM_W   = 12;
  localparam int STEP_W  = 16;
  localparam int MODE_W  = 15;
  localparam int PACK_W  = 64;
  localparam int FLD_W   = 16;
  localparam int IDX_W   = 2;
  localparam int CNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam int CX_W    = 35;
  localparam int W_W     = 34;
  localparam int H_W     = 52;
  localparam int SR_W    = 22;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 64;
  localparam int NUM_W   = 56;
  localparam int BIAS_W  = 31;
  localparam int CDIV_W  = 31;
  localparam int DEN_W   = 15;

  localparam logic [FLD_W-1:0] RATIO_ONE = 16'd4096;
  localparam logic [H_W-1:0]   HUGE_SIDE = 52'h100_0000_0000;
  localparam logic [18:0]      BIAS_MUL  = 19'd262148;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZES    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZES    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIOS       = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [ROW_W-1:0] cell_col;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_max;
    logic                      last_box;
  } out_word_t;

  typedef struct packed {
    logic             load;
    logic             side_sq;
    logic             prep_max;
    logic             sqrt_start;
    logic             sqrt_ratio;
    logic             side_root;
    logic             hdiv_start;
    logic             h_load;
    logic             corner_start;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] min_idx;
    logic [IDX_W-1:0] rat_idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic hdiv_done;
    logic corner_done;
    logic sr_zero;
  } sts_t;

endpackage
`default_nettype wire

[sv/pbg_udiv.sv]
// ---------------------------------------------------------------------------
// pbg_udiv: radix-2 restoring unsigned divider
// One quotient bit per cycle from start to the done pulse.
// ---------------------------------------------------------------------------
`default_nettype none
module pbg_udiv #(
  parameter int NW = 31,
  parameter int DW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

[sv/pbg_isqrt.sv]
// ---------------------------------------------------------------------------
// pbg_isqrt: iterative floor square root of a 64-bit value
// Two radicand bits per cycle from start to the done pulse.
// ---------------------------------------------------------------------------
`default_nettype none
module pbg_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pbg_pkg::RAD_W-1:0] rad,
  output logic                           done,
  output logic [pbg_pkg::ROOT_W-1:0]     root
);

  localparam int RW = pbg_pkg::RAD_W;

  logic          run_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [RW-1:0] v_r;
  logic [RW-1:0] r_r;
  logic [RW-1:0] b_r;
  logic [RW:0]   rb;
  logic          ge;

  assign rb = {1'b0, r_r} + {1'b0, b_r};
  assign ge = {1'b0, v_r} >= rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= rad;
      r_r <= '0;
      b_r <= {2'b01, {(RW-2){1'b0}}};
    end else if (run_r) begin
      if (ge) begin
        v_r <= v_r - rb[RW-1:0];
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[pbg_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

[sv/pbg_datapath.sv]
// ---------------------------------------------------------------------------
// pbg_datapath: centre, side and corner arithmetic of the generator
// Holds the cell centres, the current box sides, a square root unit, the
// height divider, four corner dividers and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module pbg_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pbg_pkg::cmd_t              cmd,
  input  wire pbg_pkg::in_word_t          in_word,
  input  wire logic [pbg_pkg::DIM_W-1:0]  image_width,
  input  wire logic [pbg_pkg::DIM_W-1:0]  image_height,
  input  wire logic [pbg_pkg::STEP_W-1:0] step_x_q8,
  input  wire logic [pbg_pkg::STEP_W-1:0] step_y_q8,
  input  wire logic [7:0]                 offset_q8,
  input  wire logic [pbg_pkg::PACK_W-1:0] min_sizes_packed,
  input  wire logic [pbg_pkg::PACK_W-1:0] max_sizes_packed,
  input  wire logic [pbg_pkg::PACK_W-1:0] ratios_packed,
  output pbg_pkg::sts_t                   sts,
  output logic                            out_valid,
  output pbg_pkg::out_word_t              out_word
);

  localparam int FW = pbg_pkg::FLD_W;
  localparam int NW = pbg_pkg::NUM_W;

  localparam logic [pbg_pkg::BIAS_W-1:0] BIAS_MUL_EXT =
    pbg_pkg::BIAS_W'(pbg_pkg::BIAS_MUL);

  logic [pbg_pkg::CX_W-1:0]   cx2_r, cy2_r;
  logic [pbg_pkg::BIAS_W-1:0] bias_x_r, bias_y_r, lim_x_r, lim_y_r;
  logic [pbg_pkg::DEN_W-1:0]  den_x_r, den_y_r;
  logic [pbg_pkg::W_W-1:0]    w_r;
  logic [pbg_pkg::H_W-1:0]    h_r;
  logic [pbg_pkg::SR_W-1:0]   sr_r;
  logic [31:0]                prod_r;
  logic [3:0]                 lo_r, hi_r;
  logic                       out_valid_r;
  pbg_pkg::out_word_t         out_word_r;

  logic [FW-1:0]               mn, mx, ratio;
  logic [pbg_pkg::DIM_W-1:0]   dim_x, dim_y;
  logic [pbg_pkg::RAD_W-1:0]   rad;
  logic [pbg_pkg::ROOT_W-1:0]  root;
  logic [37:0]                 w_prod;
  logic [pbg_pkg::H_W-1:0]     hquo;
  logic signed [NW-1:0]        cx_s, cy_s, w_s, h_s, bx_s, by_s;
  logic signed [NW-1:0]        n_c [4];
  logic [pbg_pkg::BIAS_W-1:0]  lim_c [4];
  logic [pbg_pkg::DEN_W-1:0]   den_c [4];
  logic [pbg_pkg::CDIV_W-1:0]  quo_c [4];
  logic [3:0]                  cdone;
  logic [pbg_pkg::COORD_W-1:0] coord [4];

  assign mn    = min_sizes_packed[FW*cmd.min_idx +: FW];
  assign mx    = max_sizes_packed[FW*cmd.min_idx +: FW];
  assign ratio = ratios_packed[FW*cmd.rat_idx +: FW];
  assign dim_x = (image_width == '0) ? pbg_pkg::DIM_W'(1) : image_width;
  assign dim_y = (image_height == '0) ? pbg_pkg::DIM_W'(1) : image_height;
  assign rad   = cmd.sqrt_ratio ? {20'b0, ratio, 28'b0} : {prod_r, 32'b0};
  assign w_prod = mn * root[pbg_pkg::SR_W-1:0];

  pbg_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.sqrt_start),
    .rad  (rad),
    .done (sts.sqrt_done),
    .root (root)
  );

  pbg_udiv #(.NW(pbg_pkg::H_W), .DW(pbg_pkg::SR_W)) u_hdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.hdiv_start),
    .num  ({mn, 36'b0}),
    .den  (sr_r),
    .done (sts.hdiv_done),
    .quo  (hquo)
  );

  assign sts.sr_zero     = (sr_r == '0);
  assign sts.corner_done = &cdone;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx2_r    <= {34'({in_word.cell_col, offset_q8}) * step_x_q8, 1'b0};
      cy2_r    <= {34'({in_word.cell_row, offset_q8}) * step_y_q8, 1'b0};
      bias_x_r <= dim_x * BIAS_MUL_EXT;
      bias_y_r <= dim_y * BIAS_MUL_EXT;
      lim_x_r  <= {dim_x, 19'b0};
      lim_y_r  <= {dim_y, 19'b0};
      den_x_r  <= {dim_x, 3'b0};
      den_y_r  <= {dim_y, 3'b0};
    end
    if (cmd.side_sq) begin
      w_r <= pbg_pkg::W_W'({mn, 16'b0});
      h_r <= pbg_pkg::H_W'({mn, 16'b0});
    end
    if (cmd.prep_max) begin
      prod_r <= mn * mx;
    end
    if (cmd.side_root) begin
      if (cmd.sqrt_ratio) begin
        sr_r <= root[pbg_pkg::SR_W-1:0];
        w_r  <= w_prod[37:4];
        h_r  <= pbg_pkg::HUGE_SIDE;
      end else begin
        w_r <= pbg_pkg::W_W'(root);
        h_r <= pbg_pkg::H_W'(root);
      end
    end
    if (cmd.h_load) begin
      h_r <= hquo;
    end
  end

  always_comb begin
    cx_s = $signed({{(NW-pbg_pkg::CX_W){1'b0}}, cx2_r});
    cy_s = $signed({{(NW-pbg_pkg::CX_W){1'b0}}, cy2_r});
    w_s  = $signed({{(NW-pbg_pkg::W_W){1'b0}}, w_r});
    h_s  = $signed({{(NW-pbg_pkg::H_W){1'b0}}, h_r});
    bx_s = $signed({{(NW-pbg_pkg::BIAS_W){1'b0}}, bias_x_r});
    by_s = $signed({{(NW-pbg_pkg::BIAS_W){1'b0}}, bias_y_r});
    n_c[0] = cx_s - w_s + bx_s;
    n_c[1] = cy_s - h_s + by_s;
    n_c[2] = cx_s + w_s + bx_s;
    n_c[3] = cy_s + h_s + by_s;
    lim_c[0] = lim_x_r;
    lim_c[1] = lim_y_r;
    lim_c[2] = lim_x_r;
    lim_c[3] = lim_y_r;
    den_c[0] = den_x_r;
    den_c[1] = den_y_r;
    den_c[2] = den_x_r;
    den_c[3] = den_y_r;
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    pbg_udiv #(.NW(pbg_pkg::CDIV_W), .DW(pbg_pkg::DEN_W)) u_cdiv (
      .clk  (clk),
      .rst_n(rst_n),
      .start(cmd.corner_start),
      .num  (n_c[i][pbg_pkg::CDIV_W-1:0]),
      .den  (den_c[i]),
      .done (cdone[i]),
      .quo  (quo_c[i])
    );

    always_ff @(posedge clk) begin
      if (cmd.corner_start) begin
        lo_r[i] <= n_c[i][NW-1];
        hi_r[i] <= n_c[i] >= $signed({{(NW-pbg_pkg::BIAS_W){1'b0}}, lim_c[i]});
      end
    end

    assign coord[i] = lo_r[i] ? 16'h8000 :
                      hi_r[i] ? 16'h7FFF : {~quo_c[i][15], quo_c[i][14:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r.x_min    <= coord[0];
      out_word_r.y_min    <= coord[1];
      out_word_r.x_max    <= coord[2];
      out_word_r.y_max    <= coord[3];
      out_word_r.last_box <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

[sv/pbg_ctrl.sv]
// ---------------------------------------------------------------------------
// pbg_ctrl: box sequencer of the generator
// Walks the minimum sizes, the optional max square and the aspect ratios of
// one cell and steps the datapath units through each box.
// ---------------------------------------------------------------------------
`default_nettype none
module pbg_ctrl #(
  parameter int MAX_MIN_SIZES = 4,
  parameter int MAX_RATIOS    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pbg_pkg::MODE_W-1:0] prior_mode,
  input  wire logic [pbg_pkg::PACK_W-1:0] ratios_packed,
  input  wire pbg_pkg::sts_t              sts,
  output pbg_pkg::cmd_t                   cmd,
  output logic                            busy
);

  localparam int FW = pbg_pkg::FLD_W;
  localparam int CW = pbg_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEL, S_MAX_MUL, S_SQRT, S_HDIV_GO, S_HDIV,
    S_CORNER_GO, S_CORNER, S_EMIT
  } state_t;

  typedef enum logic [1:0] {K_SQ, K_MAX, K_RAT} kind_t;

  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [pbg_pkg::IDX_W-1:0] s_r, s_nxt;
  logic [CW-1:0]            r_r, r_nxt;

  logic [CW-1:0] nmin, nrat;
  logic          max_en, s_last, last_c;
  logic [3:0]    rat_ok;
  logic [FW-1:0] ratio;

  function automatic logic more_rat(input logic [CW-1:0] from, input logic [CW-1:0] cnt,
                                    input logic [3:0] ok);
    logic any;
    any = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (CW'(j) >= from && CW'(j) < cnt && ok[j]) begin
        any = 1'b1;
      end
    end
    return any;
  endfunction

  always_comb begin
    nmin = (prior_mode[10:8] > CW'(MAX_MIN_SIZES)) ? CW'(MAX_MIN_SIZES) : prior_mode[10:8];
    nrat = (prior_mode[14:12] > CW'(MAX_RATIOS)) ? CW'(MAX_RATIOS) : prior_mode[14:12];
    max_en = prior_mode[11];
    for (int j = 0; j < 4; j++) begin
      rat_ok[j] = ratios_packed[FW*j +: FW] != pbg_pkg::RATIO_ONE;
    end
    ratio  = ratios_packed[FW*r_r[pbg_pkg::IDX_W-1:0] +: FW];
    s_last = ({1'b0, s_r} + CW'(1)) == nmin;
    case (kind_r)
      K_SQ:    last_c = !(max_en || more_rat('0, nrat, rat_ok) || !s_last);
      K_MAX:   last_c = !(more_rat('0, nrat, rat_ok) || !s_last);
      K_RAT:   last_c = !(more_rat(r_r + CW'(1), nrat, rat_ok) || !s_last);
      default: last_c = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    s_nxt     = s_r;
    r_nxt     = r_r;
    cmd            = '0;
    cmd.min_idx    = s_r;
    cmd.rat_idx    = r_r[pbg_pkg::IDX_W-1:0];
    cmd.sqrt_ratio = (kind_r == K_RAT);
    cmd.last       = last_c;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          kind_nxt = K_SQ;
          s_nxt    = '0;
          r_nxt    = '0;
          if (nmin != '0) begin
            state_nxt = S_SEL;
          end
        end
      end
      S_SEL: begin
        case (kind_r)
          K_SQ: begin
            cmd.side_sq = 1'b1;
            state_nxt   = S_CORNER_GO;
          end
          K_MAX: begin
            cmd.prep_max = 1'b1;
            state_nxt    = S_MAX_MUL;
          end
          default: begin
            if (r_r >= nrat) begin
              s_nxt    = s_r + 1'b1;
              kind_nxt = K_SQ;
              r_nxt    = '0;
            end else if (ratio == pbg_pkg::RATIO_ONE) begin
              r_nxt = r_r + 1'b1;
            end else begin
              cmd.sqrt_start = 1'b1;
              state_nxt      = S_SQRT;
            end
          end
        endcase
      end
      S_MAX_MUL: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQRT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.side_root = 1'b1;
          state_nxt     = (kind_r == K_RAT) ? S_HDIV_GO : S_CORNER_GO;
        end
      end
      S_HDIV_GO: begin
        if (sts.sr_zero) begin
          state_nxt = S_CORNER_GO;
        end else begin
          cmd.hdiv_start = 1'b1;
          state_nxt      = S_HDIV;
        end
      end
      S_HDIV: begin
        if (sts.hdiv_done) begin
          cmd.h_load = 1'b1;
          state_nxt  = S_CORNER_GO;
        end
      end
      S_CORNER_GO: begin
        cmd.corner_start = 1'b1;
        state_nxt        = S_CORNER;
      end
      S_CORNER: begin
        if (sts.corner_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (last_c) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SEL;
          case (kind_r)
            K_SQ: begin
              kind_nxt = max_en ? K_MAX : K_RAT;
              r_nxt    = '0;
            end
            K_MAX: begin
              kind_nxt = K_RAT;
              r_nxt    = '0;
            end
            default: begin
              r_nxt = r_r + 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_SQ;
      s_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      s_r     <= s_nxt;
      r_r     <= r_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[sv/prior_box_generator.sv]
// ---------------------------------------------------------------------------
// prior_box_generator: prior box generator for one feature-map cell
// Accepts a cell index and emits its prior boxes as saturated Q2.14 corners.
//
//   channel | ports                       | handshake
//   --------+-----------------------------+--------------------------------
//   input   | start, busy, in_word        | taken when start and not busy
//   result  | out_valid, out_word         | one-cycle strobe per word
//   config  | cfg_we, cfg_index, cfg_data | written when cfg_we is high
//
// A plain square box runs through the 31-step corner dividers; the max
// square adds the 32-step square root, and an aspect-ratio box adds the
// square root and the 52-step height divider, which a zero ratio skips.
// A skipped unit ratio or a move to the next size adds a selection pass.
// A cell with no minimum sizes is taken without leaving idle and yields no word.
// Reset is synchronous and returns the configuration and control registers to their defaults.
// Results cannot be stalled; busy stays high until the last box leaves.
// ---------------------------------------------------------------------------
`default_nettype none
module prior_box_generator #(
  parameter int MAX_MIN_SIZES = 4,
  parameter int MAX_RATIOS    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pbg_pkg::in_word_t             in_word,
  output logic                               out_valid,
  output pbg_pkg::out_word_t                 out_word,
  input  wire logic                          cfg_we,
  input  wire logic [pbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbg_pkg::PACK_W-1:0]    cfg_data
);

  logic [pbg_pkg::DIM_W-1:0]  image_width_r, image_height_r;
  logic [pbg_pkg::STEP_W-1:0] step_x_r, step_y_r;
  logic [pbg_pkg::MODE_W-1:0] prior_mode_r;
  logic [pbg_pkg::PACK_W-1:0] min_sizes_r, max_sizes_r, ratios_r;

  pbg_pkg::cmd_t cmd;
  pbg_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 12'd300;
      image_height_r <= 12'd300;
      step_x_r       <= 16'd2048;
      step_y_r       <= 16'd2048;
      prior_mode_r   <= 15'd4480;
      min_sizes_r    <= 64'd30;
      max_sizes_r    <= 64'd60;
      ratios_r       <= 64'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        pbg_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[pbg_pkg::DIM_W-1:0];
        pbg_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[pbg_pkg::DIM_W-1:0];
        pbg_pkg::CFG_STEP_X:       step_x_r       <= cfg_data[pbg_pkg::STEP_W-1:0];
        pbg_pkg::CFG_STEP_Y:       step_y_r       <= cfg_data[pbg_pkg::STEP_W-1:0];
        pbg_pkg::CFG_PRIOR_MODE:   prior_mode_r   <= cfg_data[pbg_pkg::MODE_W-1:0];
        pbg_pkg::CFG_MIN_SIZES:    min_sizes_r    <= cfg_data;
        pbg_pkg::CFG_MAX_SIZES:    max_sizes_r    <= cfg_data;
        pbg_pkg::CFG_RATIOS:       ratios_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pbg_ctrl #(
    .MAX_MIN_SIZES(MAX_MIN_SIZES),
    .MAX_RATIOS   (MAX_RATIOS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .prior_mode   (prior_mode_r),
    .ratios_packed(ratios_r),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  pbg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_word         (in_word),
    .image_width     (image_width_r),
    .image_height    (image_height_r),
    .step_x_q8       (step_x_r),
    .step_y_q8       (step_y_r),
    .offset_q8       (prior_mode_r[7:0]),
    .min_sizes_packed(min_sizes_r),
    .max_sizes_packed(max_sizes_r),
    .ratios_packed   (ratios_r),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_word        (out_word)
  );

`ifndef SYNTHESIS
  // The final word of a cell leaves exactly as the sequencer goes idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_word.last_box))
    else $error("busy does not match last_box on a result word");

  // Boxes take many cycles each, so result words never come back to back.
  a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result words in consecutive cycles");

  // The sequencer leaves idle only on an accepted cell.
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");
`endif

endmodule
`default_nettype wire
